// ===== design/conv2d_3x3_valid_defines.svh =====
// Assertion macros shared by the convolution block.
`ifndef CONV2D_3X3_VALID_DEFINES_SVH
`define CONV2D_3X3_VALID_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on the block clock outside reset.
`define C2D_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked on the block clock outside reset.
`define C2D_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define C2D_ASSERT_IMP(lbl, ante, cons, msg)
`define C2D_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/c2d_pkg.sv =====
// Types and constants shared by the 3x3 convolution modules.
package c2d_pkg;

   // Configuration register indexes.
   localparam int C2D_CSR_AW = 3;
   typedef enum logic [C2D_CSR_AW-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_KERNEL_ROW_0 = 3'd2,
      CSR_KERNEL_ROW_1 = 3'd3,
      CSR_KERNEL_ROW_2 = 3'd4
   } c2d_csr_type;

   // Image size limits and reset values.
   localparam logic [6:0] IMG_MIN_DIM    = 7'd3;
   localparam logic [6:0] IMG_MAX_HEIGHT = 7'd64;
   localparam logic [6:0] IMG_RESET_DIM  = 7'd4;

   // Data widths.
   localparam int PIX_W    = 16;
   localparam int LINE_W   = 2 * PIX_W;
   localparam int KROW_W   = 48;
   localparam int PROD_W   = 32;
   localparam int ROWSUM_W = 34;
   localparam int SUM_W    = 35;

   typedef logic [2:0][KROW_W-1:0] c2d_kernel_type;
   typedef logic signed [PROD_W-1:0] c2d_prod_type;

   // Output coordinates and frame flag travelling with a request.
   typedef struct packed {
      logic       frame_last;
      logic [5:0] out_row;
      logic [5:0] out_col;
   } c2d_tag_type;

   // Per-request control passed from the counters to the window stage.
   typedef struct packed {
      logic        emit;
      c2d_tag_type tag;
   } c2d_item_type;

   // The nine products and their tag.
   typedef struct packed {
      c2d_prod_type [8:0] prod;
      c2d_tag_type        tag;
   } c2d_prod_bundle_type;

endpackage

// ===== design/c2d_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module c2d_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read port; data holds between reads.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/c2d_ctrl.sv =====
// Configuration registers, raster counters and request intake.
module c2d_ctrl #(
   parameter int MAX_WIDTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_frame_start,
   input  logic                                 csr_wr_en,
   input  logic [c2d_pkg::C2D_CSR_AW-1:0]       csr_addr,
   input  logic [c2d_pkg::KROW_W-1:0]           csr_wdata,
   input  logic                                 s1_ready,
   output logic                                 item_valid,
   output c2d_pkg::c2d_item_type                item_info,
   output logic [$clog2(MAX_WIDTH)-1:0]         item_addr,
   output c2d_pkg::c2d_kernel_type              kernel
);
   import c2d_pkg::*;

   localparam int AW   = $clog2(MAX_WIDTH);
   localparam int CMPW = ((AW > 7) ? AW : 7) + 1;
   localparam logic [6:0] WMAX = (MAX_WIDTH > 127) ? 7'd127 : 7'(MAX_WIDTH);

   logic [6:0]     width_ff, width_in;
   logic [6:0]     height_ff, height_in;
   c2d_kernel_type kernel_ff, kernel_in;
   logic [AW-1:0]  col_ff, col_in;
   logic [6:0]     row_ff, row_in;

   logic [6:0]     w_eff, h_eff;
   logic [AW-1:0]  col_eff;
   logic [6:0]     row_eff;
   logic           accept, process, col_last, row_last;

   // Configuration writes.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      kernel_in = kernel_ff;
      if (csr_wr_en) begin
         case (c2d_csr_type'(csr_addr))
            CSR_IMAGE_WIDTH:  width_in     = csr_wdata[6:0];
            CSR_IMAGE_HEIGHT: height_in    = csr_wdata[6:0];
            CSR_KERNEL_ROW_0: kernel_in[0] = csr_wdata;
            CSR_KERNEL_ROW_1: kernel_in[1] = csr_wdata;
            CSR_KERNEL_ROW_2: kernel_in[2] = csr_wdata;
            default:          width_in     = width_ff;
         endcase
      end
   end

   // Effective image size, clamped to the supported range.
   always_comb begin
      if (width_ff < IMG_MIN_DIM) begin
         w_eff = IMG_MIN_DIM;
      end else if (width_ff > WMAX) begin
         w_eff = WMAX;
      end else begin
         w_eff = width_ff;
      end
      if (height_ff < IMG_MIN_DIM) begin
         h_eff = IMG_MIN_DIM;
      end else if (height_ff > IMG_MAX_HEIGHT) begin
         h_eff = IMG_MAX_HEIGHT;
      end else begin
         h_eff = height_ff;
      end
   end

   // Position of the incoming pixel; a frame start restarts the raster.
   assign col_eff  = req_frame_start ? '0 : col_ff;
   assign row_eff  = req_frame_start ? '0 : row_ff;
   assign accept   = req_valid && s1_ready;
   assign process  = accept && (row_eff < h_eff);
   assign col_last = (CMPW'(col_eff) + CMPW'(1)) >= CMPW'(w_eff);
   assign row_last = (row_eff + 7'd1) >= h_eff;

   // Raster counters advance on every pixel inside the frame.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (process) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_eff + 7'd1;
         end else begin
            col_in = col_eff + AW'(1);
            row_in = row_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMG_RESET_DIM;
         height_ff <= IMG_RESET_DIM;
         kernel_ff <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         kernel_ff <= kernel_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   // Request handed to the window stage.
   always_comb begin
      item_info.emit           = (row_eff >= 7'd2) && (col_eff >= AW'(2));
      item_info.tag.frame_last = row_last && col_last;
      item_info.tag.out_row    = 6'(row_eff - 7'd2);
      item_info.tag.out_col    = 6'(col_eff - AW'(2));
   end

   assign item_valid = process;
   assign item_addr  = col_eff;
   assign req_stall  = !s1_ready;
   assign kernel     = kernel_ff;

endmodule

// ===== design/c2d_window.sv =====
// Line store read-modify-write, sliding window and the nine multipliers.
module c2d_window #(
   parameter int AW = 6
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 item_valid,
   input  c2d_pkg::c2d_item_type                item_info,
   input  logic [AW-1:0]                        item_addr,
   input  logic [c2d_pkg::PIX_W-1:0]            item_pixel,
   input  c2d_pkg::c2d_kernel_type              kernel,
   input  logic [c2d_pkg::LINE_W-1:0]           ram_rdata,
   output logic                                 ram_we,
   output logic [AW-1:0]                        ram_waddr,
   output logic [c2d_pkg::LINE_W-1:0]           ram_wdata,
   output logic                                 s1_ready,
   output logic                                 prod_valid,
   output c2d_pkg::c2d_prod_bundle_type         prod_data,
   input  logic                                 prod_ready
);
   import c2d_pkg::*;

   logic                s1_valid_ff;
   c2d_item_type        s1_info_ff;
   logic [AW-1:0]       s1_addr_ff;
   logic [PIX_W-1:0]    s1_pixel_ff;
   logic                fwd_ff;
   logic [LINE_W-1:0]   fwd_data_ff;
   logic [PIX_W-1:0]    wcol_ff [6];
   logic                s2_valid_ff;
   c2d_prod_bundle_type s2_data_ff;

   logic [LINE_W-1:0]   line_word;
   logic [PIX_W-1:0]    top, mid;
   logic [PIX_W-1:0]    win [3][3];
   c2d_prod_type [8:0]  prod;
   logic                s1_move, s2_move, fwd_hit;

   // Pipeline flow: a stage empties into the next when that one has room.
   assign s2_move  = s2_valid_ff && prod_ready;
   assign s1_move  = s1_valid_ff && (!s1_info_ff.emit || !s2_valid_ff || s2_move);
   assign s1_ready = !s1_valid_ff || s1_move;

   // Line store row for this column; a write to the same column in the read cycle
   // is forwarded.
   assign line_word = fwd_ff ? fwd_data_ff : ram_rdata;
   assign top       = line_word[LINE_W-1:PIX_W];
   assign mid       = line_word[PIX_W-1:0];

   // Shift the column pair up one row in the line stores.
   assign ram_we    = s1_move;
   assign ram_waddr = s1_addr_ff;
   assign ram_wdata = {mid, s1_pixel_ff};
   assign fwd_hit   = item_valid && ram_we && (item_addr == s1_addr_ff);

   // Window: row 0 is the oldest row, column 0 the leftmost column.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win[r][0] = wcol_ff[r];
         win[r][1] = wcol_ff[3 + r];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = s1_pixel_ff;
   end

   // Nine independent signed multiplies.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod[r * 3 + c] = PROD_W'($signed(win[r][c]) *
                                      $signed(kernel[r][c * PIX_W +: PIX_W]));
         end
      end
   end

   // Stage one: request waiting for its line store data.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && item_valid) begin
         s1_info_ff  <= item_info;
         s1_addr_ff  <= item_addr;
         s1_pixel_ff <= item_pixel;
         fwd_ff      <= fwd_hit;
         fwd_data_ff <= ram_wdata;
      end
   end

   // Window columns slide left as each pixel leaves stage one.
   always_ff @(posedge clock) begin
      if (s1_move) begin
         for (int r = 0; r < 3; r++) begin
            wcol_ff[r]     <= win[r][1];
            wcol_ff[3 + r] <= win[r][2];
         end
      end
   end

   // Stage two: registered products.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (!s2_valid_ff || s2_move) begin
         s2_valid_ff <= s1_move && s1_info_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if ((!s2_valid_ff || s2_move) && s1_move && s1_info_ff.emit) begin
         s2_data_ff.prod <= prod;
         s2_data_ff.tag  <= s1_info_ff.tag;
      end
   end

   assign prod_valid = s2_valid_ff;
   assign prod_data  = s2_data_ff;

endmodule

// ===== design/c2d_adder.sv =====
// Two-level adder tree and the output register of the result channel.
module c2d_adder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 prod_valid,
   input  c2d_pkg::c2d_prod_bundle_type         prod_data,
   output logic                                 prod_ready,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [c2d_pkg::SUM_W-1:0]     rsp_conv_sum,
   output logic [5:0]                           rsp_out_row,
   output logic [5:0]                           rsp_out_col,
   output logic                                 rsp_frame_last
);
   import c2d_pkg::*;

   logic                       s3_valid_ff;
   logic signed [ROWSUM_W-1:0] s3_rowsum_ff [3];
   c2d_tag_type                s3_tag_ff;
   logic                       out_valid_ff;
   logic signed [SUM_W-1:0]    out_sum_ff;
   c2d_tag_type                out_tag_ff;

   logic signed [ROWSUM_W-1:0] rowsum [3];
   logic signed [SUM_W-1:0]    total;
   logic                       out_room, s3_move, s3_room;

   assign out_room   = !out_valid_ff || !rsp_stall;
   assign s3_move    = s3_valid_ff && out_room;
   assign s3_room    = !s3_valid_ff || s3_move;
   assign prod_ready = s3_room;

   // Row sums of three products each.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         rowsum[r] = ROWSUM_W'($signed(prod_data.prod[r * 3])) +
                     ROWSUM_W'($signed(prod_data.prod[r * 3 + 1])) +
                     ROWSUM_W'($signed(prod_data.prod[r * 3 + 2]));
      end
   end

   // Final sum of the three row sums.
   assign total = SUM_W'(s3_rowsum_ff[0]) + SUM_W'(s3_rowsum_ff[1]) +
                  SUM_W'(s3_rowsum_ff[2]);

   // Stage three: row sums.
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_room) begin
         s3_valid_ff <= prod_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_room && prod_valid) begin
         s3_rowsum_ff <= rowsum;
         s3_tag_ff    <= prod_data.tag;
      end
   end

   // Output register; holds while the result is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_room) begin
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_move) begin
         out_sum_ff <= total;
         out_tag_ff <= s3_tag_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_conv_sum   = out_sum_ff;
   assign rsp_out_row    = out_tag_ff.out_row;
   assign rsp_out_col    = out_tag_ff.out_col;
   assign rsp_frame_last = out_tag_ff.frame_last;

endmodule

// ===== design/conv2d_3x3_valid.sv =====
// Top level of the streaming 3x3 valid convolution.
// Streaming 3x3 convolution, stride one, no padding. Pixels (signed Q8.8) enter
// in raster order, one per clock, with frame start marking row 0 column 0. The
// two previous rows live in one line store RAM indexed by column, so each pixel
// costs one read and one write; the block sustains one pixel per clock whenever
// the result side is not stalling. A result (exact signed Q19.16 sum, output
// row and column, last-of-frame flag) appears on the result channel once its
// pixel has gone through the line store read and the nine multipliers, then
// through the row sums and then the final sum, which lands in the output
// register. Pixels beyond the configured height are taken and dropped until
// the next frame start. Width and height are clamped to 3..MAX_WIDTH and
// 3..64. Change configuration only while no request is in
// flight. The line stores need no clearing after reset.
module conv2d_3x3_valid #(
   parameter int MAX_WIDTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [c2d_pkg::PIX_W-1:0]     req_pixel,
   input  logic                                 req_frame_start,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [c2d_pkg::SUM_W-1:0]     rsp_conv_sum,
   output logic [5:0]                           rsp_out_row,
   output logic [5:0]                           rsp_out_col,
   output logic                                 rsp_frame_last,
   input  logic                                 csr_wr_en,
   input  logic [c2d_pkg::C2D_CSR_AW-1:0]       csr_addr,
   input  logic [c2d_pkg::KROW_W-1:0]           csr_wdata
);
   import c2d_pkg::*;

`include "conv2d_3x3_valid_defines.svh"

   localparam int AW = $clog2(MAX_WIDTH);

   logic                s1_ready;
   logic                item_valid;
   c2d_item_type        item_info;
   logic [AW-1:0]       item_addr;
   c2d_kernel_type      kernel;
   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [LINE_W-1:0]   ram_wdata;
   logic [LINE_W-1:0]   ram_rdata;
   logic                prod_valid;
   logic                prod_ready;
   c2d_prod_bundle_type prod_data;

   // Counters, configuration and intake.
   c2d_ctrl #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_frame_start(req_frame_start),
      .csr_wr_en      (csr_wr_en),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .s1_ready       (s1_ready),
      .item_valid     (item_valid),
      .item_info      (item_info),
      .item_addr      (item_addr),
      .kernel         (kernel)
   );

   // Line stores: upper row in the high half, middle row in the low half.
   c2d_ram #(
      .WIDTH(LINE_W),
      .DEPTH(MAX_WIDTH)
   ) u_line_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (item_valid),
      .raddr(item_addr),
      .rdata(ram_rdata)
   );

   // Window and multipliers.
   c2d_window #(
      .AW(AW)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .item_valid(item_valid),
      .item_info (item_info),
      .item_addr (item_addr),
      .item_pixel(req_pixel),
      .kernel    (kernel),
      .ram_rdata (ram_rdata),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .s1_ready  (s1_ready),
      .prod_valid(prod_valid),
      .prod_data (prod_data),
      .prod_ready(prod_ready)
   );

   // Adder tree and result register.
   c2d_adder u_adder (
      .clock         (clock),
      .reset         (reset),
      .prod_valid    (prod_valid),
      .prod_data     (prod_data),
      .prod_ready    (prod_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_conv_sum  (rsp_conv_sum),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_frame_last(rsp_frame_last)
   );

   // A line store read only happens for a request taken in that cycle.
   `C2D_ASSERT_IMP(a_read_on_accept, item_valid, req_valid && !req_stall, "line read without request")
   // A frame start always lands in the frame and reads column zero.
   `C2D_ASSERT_IMP(a_start_reads_col0, req_valid && !req_stall && req_frame_start, item_valid && item_addr == '0, "frame start not at column zero")
   // Nothing is pending or written right after reset.
   `C2D_ASSERT_IMP(a_reset_empty, $past(reset), !rsp_valid && !ram_we, "pipeline not empty after reset")

endmodule

// ===== tb/conv2d_checker.sv =====
// Checker for the 3x3 convolution: predicts each window sum and compares results.
`timescale 1ns / 100ps

module conv2d_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic signed [c2d_pkg::PIX_W-1:0]  req_pixel,
   input  logic                              req_frame_start,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic signed [c2d_pkg::SUM_W-1:0]  rsp_conv_sum,
   input  logic [5:0]                        rsp_out_row,
   input  logic [5:0]                        rsp_out_col,
   input  logic                              rsp_frame_last,
   input  logic                              csr_wr_en,
   input  logic [c2d_pkg::C2D_CSR_AW-1:0]    csr_addr,
   input  logic [c2d_pkg::KROW_W-1:0]        csr_wdata,
   output int                                fail_count,
   output int                                pending_count
);
   import c2d_pkg::*;

   localparam int LINE_DEPTH = 64;

   typedef struct {
      logic signed [SUM_W-1:0] conv_sum;
      logic [5:0]              out_row;
      logic [5:0]              out_col;
      logic                    frame_last;
   } window_sum_type;

   // Shadow copy of the configuration registers.
   logic [6:0]        width_reg;
   logic [6:0]        height_reg;
   logic [KROW_W-1:0] kernel_rows [3];

   // Shadow copy of the line stores, window and raster counters.
   logic [PIX_W-1:0]  upper_line [LINE_DEPTH];
   logic [PIX_W-1:0]  middle_line [LINE_DEPTH];
   logic [PIX_W-1:0]  window_cols [6];
   int                col_count;
   int                row_count;

   window_sum_type    expected_sums [$];
   int                errors = 0;

   // Sizes outside the supported range are clamped when used.
   function automatic int clamp_dim(input logic [6:0] v);
      if (v < IMG_MIN_DIM) return IMG_MIN_DIM;
      if (v > IMG_MAX_HEIGHT) return IMG_MAX_HEIGHT;
      return v;
   endfunction

   // Advance the raster position for one pixel and queue the window sum it yields.
   task automatic predict_window_sum(input logic [PIX_W-1:0] px, input logic fs);
      int w;
      int h;
      int col;
      int row;
      int r;
      int c;
      logic [PIX_W-1:0]  top_px;
      logic [PIX_W-1:0]  mid_px;
      logic [PIX_W-1:0]  win [3][3];
      logic [PIX_W-1:0]  weight;
      longint            acc;
      window_sum_type    res;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      if (fs) begin
         col_count = 0;
         row_count = 0;
      end
      // A finished frame drops pixels until the next frame start.
      if (row_count >= h) return;
      col = col_count;
      row = row_count;
      if (col >= LINE_DEPTH) col = LINE_DEPTH - 1;

      top_px = upper_line[col];
      mid_px = middle_line[col];
      upper_line[col] = mid_px;
      middle_line[col] = px;

      // Row 0 of the window is the oldest row, column 0 the leftmost column.
      for (r = 0; r < 3; r++) begin
         win[r][0] = window_cols[r];
         win[r][1] = window_cols[3 + r];
      end
      win[0][2] = top_px;
      win[1][2] = mid_px;
      win[2][2] = px;
      for (r = 0; r < 3; r++) begin
         window_cols[r] = win[r][1];
         window_cols[3 + r] = win[r][2];
      end

      res.frame_last = (row + 1 >= h) && (col + 1 >= w);
      if (col + 1 >= w) begin
         col_count = 0;
         row_count = row + 1;
      end else begin
         col_count = col + 1;
      end
      if (row < 2 || col < 2) return;

      acc = 0;
      for (r = 0; r < 3; r++) begin
         for (c = 0; c < 3; c++) begin
            weight = kernel_rows[r][16*c +: 16];
            acc += longint'($signed(win[r][c])) * longint'($signed(weight));
         end
      end
      res.conv_sum = acc[SUM_W-1:0];
      res.out_row = 6'(row - 2);
      res.out_col = 6'(col - 2);
      expected_sums.push_back(res);
   endtask

   // Compare one accepted result with the oldest expected window sum.
   task automatic check_window_sum();
      window_sum_type exp_sum;
      if (expected_sums.size() == 0) begin
         $error("result with no request waiting: conv_sum %0d row %0d col %0d",
                rsp_conv_sum, rsp_out_row, rsp_out_col);
         errors++;
         return;
      end
      exp_sum = expected_sums.pop_front();
      if (rsp_conv_sum !== exp_sum.conv_sum) begin
         $error("conv_sum expected %0d actual %0d", exp_sum.conv_sum, rsp_conv_sum);
         errors++;
      end
      if (rsp_out_row !== exp_sum.out_row) begin
         $error("out_row expected %0d actual %0d", exp_sum.out_row, rsp_out_row);
         errors++;
      end
      if (rsp_out_col !== exp_sum.out_col) begin
         $error("out_col expected %0d actual %0d", exp_sum.out_col, rsp_out_col);
         errors++;
      end
      if (rsp_frame_last !== exp_sum.frame_last) begin
         $error("frame_last expected %0d actual %0d", exp_sum.frame_last, rsp_frame_last);
         errors++;
      end
   endtask

   // Watch the register port and both channels at every rising edge.
   always @(posedge clock) begin
      if (reset) begin
         width_reg = IMG_RESET_DIM;
         height_reg = IMG_RESET_DIM;
         for (int k = 0; k < 3; k++) kernel_rows[k] = '0;
         for (int k = 0; k < LINE_DEPTH; k++) begin
            upper_line[k] = '0;
            middle_line[k] = '0;
         end
         for (int k = 0; k < 6; k++) window_cols[k] = '0;
         col_count = 0;
         row_count = 0;
         expected_sums.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_addr)
               CSR_IMAGE_WIDTH:  width_reg = csr_wdata[6:0];
               CSR_IMAGE_HEIGHT: height_reg = csr_wdata[6:0];
               CSR_KERNEL_ROW_0: kernel_rows[0] = csr_wdata;
               CSR_KERNEL_ROW_1: kernel_rows[1] = csr_wdata;
               CSR_KERNEL_ROW_2: kernel_rows[2] = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) check_window_sum();
         if (req_valid && !req_stall) predict_window_sum(req_pixel, req_frame_start);
      end
      fail_count <= errors;
      pending_count <= expected_sums.size();
   end

endmodule

// ===== tb/tb.sv =====
// Top of the convolution testbench: clock, reset, stimulus and the verdict.
`timescale 1ns / 100ps

module tb;
   import c2d_pkg::*;

   localparam logic [PIX_W-1:0]  PIX_MIN = 16'h8000;
   localparam logic [PIX_W-1:0]  PIX_MAX = 16'h7FFF;
   localparam logic [KROW_W-1:0] KROW_MIN = {3{16'h8000}};
   localparam logic [KROW_W-1:0] KROW_MAX = {3{16'h7FFF}};
   localparam int RANDOM_ITEMS = 1200;
   localparam int DRAIN_CYCLES = 10;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [PIX_W-1:0]  req_pixel = '0;
   logic                     req_frame_start = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [SUM_W-1:0]  rsp_conv_sum;
   logic [5:0]               rsp_out_row;
   logic [5:0]               rsp_out_col;
   logic                     rsp_frame_last;
   logic                     csr_wr_en = 1'b0;
   logic [C2D_CSR_AW-1:0]    csr_addr = '0;
   logic [KROW_W-1:0]        csr_wdata = '0;
   int                       fail_count;
   int                       pending_count;

   int burst_left = 0;
   int stall_mode = 0;
   int stall_left = 0;
   int cur_width = 3;
   int cur_height = 3;
   int safe_width = 3;

   conv2d_3x3_valid dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_pixel, .req_frame_start,
      .rsp_valid, .rsp_stall, .rsp_conv_sum, .rsp_out_row, .rsp_out_col, .rsp_frame_last,
      .csr_wr_en, .csr_addr, .csr_wdata
   );

   conv2d_checker checker_i (
      .clock, .reset,
      .req_valid, .req_stall, .req_pixel, .req_frame_start,
      .rsp_valid, .rsp_stall, .rsp_conv_sum, .rsp_out_row, .rsp_out_col, .rsp_frame_last,
      .csr_wr_en, .csr_addr, .csr_wdata,
      .fail_count, .pending_count
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver stalls in modes of random length: free, light, heavy and solid stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = (stall_mode == 3) ? $urandom_range(1, 20) : $urandom_range(10, 60);
         end
         stall_left--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= 1'b1;
         endcase
      end
   end

   // Generous bound on the whole run.
   initial begin
      #4_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic int clamp_size(input logic [6:0] v);
      if (v < IMG_MIN_DIM) return IMG_MIN_DIM;
      if (v > IMG_MAX_HEIGHT) return IMG_MAX_HEIGHT;
      return v;
   endfunction

   // Mostly small sizes, now and then the clamped and maximum ones.
   function automatic logic [6:0] pick_size();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 7'($urandom_range(0, 2));
      if (r == 1) return 7'd64;
      if (r == 2) return 7'($urandom_range(65, 127));
      return 7'($urandom_range(3, 10));
   endfunction

   function automatic logic [KROW_W-1:0] pick_kernel_row();
      case ($urandom_range(0, 9))
         0: return KROW_MIN;
         1: return KROW_MAX;
         2: return '0;
         3: return '1;
         default: return {16'($urandom_range(0, 65535)), 32'($urandom())};
      endcase
   endfunction

   function automatic logic [PIX_W-1:0] pick_pixel();
      case ($urandom_range(0, 15))
         0: return PIX_MIN;
         1: return PIX_MAX;
         2: return '0;
         3: return '1;
         default: return 16'($urandom());
      endcase
   endfunction

   // Present one pixel request and hold it until accepted; bursts end in a gap.
   task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) < 2) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      req_frame_start <= fs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
   endtask

   // Stop sending and let every expected result and the pipeline drain.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input c2d_csr_type addr, input logic [KROW_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Write all five registers back to back.
   task automatic program_image(input logic [6:0] w, input logic [6:0] h,
                                input logic [KROW_W-1:0] k0,
                                input logic [KROW_W-1:0] k1,
                                input logic [KROW_W-1:0] k2);
      write_csr(CSR_IMAGE_WIDTH, KROW_W'(w));
      write_csr(CSR_IMAGE_HEIGHT, KROW_W'(h));
      write_csr(CSR_KERNEL_ROW_0, k0);
      write_csr(CSR_KERNEL_ROW_1, k1);
      write_csr(CSR_KERNEL_ROW_2, k2);
      csr_wr_en <= 1'b0;
      cur_width = clamp_size(w);
      cur_height = clamp_size(h);
   endtask

   // One random phase: new settings, then frames that are mostly whole.
   task automatic run_phase(input int budget, inout int sent);
      logic [6:0] w;
      logic       fs_first;
      int         frame_len;
      int         n;
      int         kind;
      int         done;
      w = pick_size();
      program_image(w, pick_size(), pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
      // Narrowing may carry on the open frame; any widening must restart it.
      fs_first = !(cur_width <= safe_width && $urandom_range(0, 2) == 0);
      safe_width = cur_width;
      done = 0;
      while (done < budget) begin
         frame_len = cur_width * cur_height;
         kind = $urandom_range(0, 9);
         n = (kind < 7) ? frame_len : $urandom_range(1, frame_len - 1);
         if (n > budget - done) n = budget - done;
         for (int i = 0; i < n; i++) send_pixel(pick_pixel(), (i == 0) && fs_first);
         done += n;
         // Occasional trailing pixels that a finished frame drops.
         if (kind == 6) begin
            repeat ($urandom_range(1, 3)) send_pixel(pick_pixel(), 1'b0);
         end
         fs_first = 1'b1;
      end
      sent += done;
   endtask

   initial begin
      int sent;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Smallest image, most negative weights: the first frame needs no frame start.
      program_image(7'd3, 7'd3, KROW_MIN, KROW_MIN, KROW_MIN);
      safe_width = 3;
      repeat (9) send_pixel(PIX_MIN, 1'b0);
      // The frame is complete, so these are dropped.
      repeat (2) send_pixel(PIX_MAX, 1'b0);
      wait_idle();

      // Zero sizes clamp to the minimum; a frame start cuts the frame short.
      program_image(7'd0, 7'd0, KROW_MAX, KROW_MAX, KROW_MAX);
      send_pixel(PIX_MAX, 1'b1);
      send_pixel('0, 1'b0);
      send_pixel('1, 1'b0);
      send_pixel(PIX_MIN, 1'b0);
      send_pixel(PIX_MIN, 1'b1);
      repeat (8) send_pixel(PIX_MIN, 1'b0);
      wait_idle();

      // Random phases with changing sizes and weights.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         run_phase($urandom_range(60, 160), sent);
         wait_idle();
      end

      if (pending_count != 0) $error("%0d expected results never arrived", pending_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
